// ----- rtl/core/gfah_pkg.sv -----
package gfah_pkg;

    localparam int ELEM_BITS     = 64;
    localparam int HASH_CTL_BITS = 7;
    localparam int CFG_IDX_BITS  = 3;

    // Horner steps folded into each pipeline stage
    localparam int STEP_BITS     = 8;
    localparam int HORNER_STAGES = ELEM_BITS / STEP_BITS;
    localparam int NUM_STAGES    = 2 * HORNER_STAGES;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MULTIPLIER  = 3'd0,
        REG_ADDEND      = 3'd1,
        REG_MODULUS_LOW = 3'd2,
        REG_HASH_BITS   = 3'd3,
        REG_TARGET      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [ELEM_BITS-1:0] element;
        logic                 is_last;
    } item_t;

endpackage

// ----- rtl/core/gf2m_affine_hash_match.sv -----
// Affine hash over GF(2^FIELD_BITS) with a target match. Each request carries one
// 64-bit element x; the block returns hash = low hash_bits bits of
// (multiplier * x mod f) XOR addend, a match flag (hash == target), the element
// when matched (zero otherwise) and the last-of-set marker. f is x^FIELD_BITS plus
// modulus_low; the modulus is not checked for irreducibility. One request is
// accepted per cycle while in_stall is low, and every request yields exactly one
// result, passing through 16 Horner stages of 8 bit-steps each
// (eight reduce the multiplier modulo f, eight multiply by the element) followed
// by the output register that applies the addend, mask and compare. The stages
// hand off with local ready, so bubbles close up while the output is stalled.
// Configuration writes are always taken (cfg_ready is tied high) and must only
// be issued while no request is in flight.
module gf2m_affine_hash_match
    import gfah_pkg::*;
#(
    parameter int FIELD_BITS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ELEM_BITS-1:0]     element,
    input  logic                     is_last,
    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ELEM_BITS-1:0]     matched_element,
    output logic [ELEM_BITS-1:0]     hash_code,
    output logic                     is_match,
    output logic                     is_last_res,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ELEM_BITS-1:0]     cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ELEM_BITS-1:0]     multiplier_reg;
    logic [ELEM_BITS-1:0]     addend_reg;
    logic [ELEM_BITS-1:0]     modulus_reg;
    logic [HASH_CTL_BITS-1:0] hash_bits_reg;
    logic [ELEM_BITS-1:0]     target_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiplier_reg <= 64'd1;
            addend_reg     <= 64'd0;
            modulus_reg    <= 64'd27;
            hash_bits_reg  <= 7'd20;
            target_reg     <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MULTIPLIER:  multiplier_reg <= cfg_data;
                REG_ADDEND:      addend_reg     <= cfg_data;
                REG_MODULUS_LOW: modulus_reg    <= cfg_data;
                REG_HASH_BITS:   hash_bits_reg  <= cfg_data[HASH_CTL_BITS-1:0];
                REG_TARGET:      target_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    // f without its implicit top term, cut to the field
    logic [FIELD_BITS-1:0] mod_low;
    assign mod_low = modulus_reg[FIELD_BITS-1:0];

    // ---------------------------------------------------------------
    // Horner pipeline
    // ---------------------------------------------------------------
    logic                  stg_valid [NUM_STAGES];
    logic                  stg_ready [NUM_STAGES];
    item_t                 stg_item  [NUM_STAGES];
    logic [FIELD_BITS-1:0] stg_ra    [NUM_STAGES];
    logic [FIELD_BITS-1:0] stg_rx    [NUM_STAGES];
    logic                  out_ready;
    item_t                 in_item;

    assign in_item.element = element;
    assign in_item.is_last = is_last;

    genvar s;
    generate
        for (s = 0; s < NUM_STAGES; s++)
        begin : g_stage
            logic                  v_in;
            logic                  r_in;
            item_t                 it_in;
            logic [FIELD_BITS-1:0] ra_in;
            logic [FIELD_BITS-1:0] rx_in;

            if (s == 0)
            begin : g_head
                assign v_in  = in_valid;
                assign it_in = in_item;
                assign ra_in = '0;
                assign rx_in = '0;
            end
            else
            begin : g_body
                assign v_in  = stg_valid[s-1];
                assign it_in = stg_item[s-1];
                assign ra_in = stg_ra[s-1];
                assign rx_in = stg_rx[s-1];
            end

            if (s == NUM_STAGES - 1)
            begin : g_tail
                assign r_in = out_ready;
            end
            else
            begin : g_link
                assign r_in = stg_ready[s+1];
            end

            gfah_stage #(
                .FIELD_BITS (FIELD_BITS),
                .STAGE      (s)
            ) u_stage (
                .clk        (clk),
                .rst_n      (rst_n),
                .valid_in   (v_in),
                .ready_out  (stg_ready[s]),
                .valid_out  (stg_valid[s]),
                .ready_in   (r_in),
                .item_in    (it_in),
                .ra_in      (ra_in),
                .rx_in      (rx_in),
                .multiplier (multiplier_reg),
                .mod_low    (mod_low),
                .item_out   (stg_item[s]),
                .ra_out     (stg_ra[s]),
                .rx_out     (stg_rx[s])
            );
        end
    endgenerate

    assign in_stall = !stg_ready[0];

    // ---------------------------------------------------------------
    // Output stage: addend, hash mask, target compare
    // ---------------------------------------------------------------
    logic                 out_valid_reg;
    logic [ELEM_BITS-1:0] matched_reg;
    logic [ELEM_BITS-1:0] hash_reg;
    logic                 match_reg;
    logic                 last_reg;
    logic [ELEM_BITS-1:0] r_full;
    logic [ELEM_BITS-1:0] kmask;
    logic [ELEM_BITS-1:0] hash_next;
    logic                 match_next;
    logic                 tail_fire;

    assign out_ready = !out_valid_reg || !out_stall;
    assign tail_fire = stg_valid[NUM_STAGES-1] && out_ready;

    always_comb
    begin
        r_full = ELEM_BITS'(stg_rx[NUM_STAGES-1]) ^ addend_reg;
        if (hash_bits_reg >= HASH_CTL_BITS'(ELEM_BITS))
            kmask = '1;
        else
            kmask = (64'd1 << hash_bits_reg) - 64'd1;
        hash_next  = r_full & kmask;
        match_next = (hash_next == target_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= stg_valid[NUM_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (tail_fire)
        begin
            hash_reg    <= hash_next;
            match_reg   <= match_next;
            matched_reg <= match_next ? stg_item[NUM_STAGES-1].element : '0;
            last_reg    <= stg_item[NUM_STAGES-1].is_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign matched_element = matched_reg;
    assign hash_code       = hash_reg;
    assign is_match        = match_reg;
    assign is_last_res     = last_reg;

`ifndef SYNTHESIS
    // an empty first stage always takes a request
    a_head_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !stg_valid[0] |-> !in_stall)
        else $error("request stalled with empty first stage");

    // an output ready for a waiting tail result then holds a valid result
    a_tail_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid[NUM_STAGES-1] && out_ready) |=> out_valid)
        else $error("tail result lost at output stage");

    // match flag agrees with the hash and target
    a_match_eq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_match == (hash_code == target_reg)))
        else $error("match flag disagrees with hash compare");

    // non-matching results carry no element
    a_no_leak: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_match) |-> (matched_element == '0))
        else $error("element echoed without a match");
`endif

endmodule

// ----- rtl/core/gfah_stage.sv -----
module gfah_stage
    import gfah_pkg::*;
#(
    parameter int FIELD_BITS = 64,
    parameter int STAGE      = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    output logic                  ready_out,
    output logic                  valid_out,
    input  logic                  ready_in,
    input  item_t                 item_in,
    input  logic [FIELD_BITS-1:0] ra_in,
    input  logic [FIELD_BITS-1:0] rx_in,
    input  logic [ELEM_BITS-1:0]  multiplier,
    input  logic [FIELD_BITS-1:0] mod_low,
    output item_t                 item_out,
    output logic [FIELD_BITS-1:0] ra_out,
    output logic [FIELD_BITS-1:0] rx_out
);

    // first half reduces the multiplier, second half multiplies the element
    localparam bit IS_X = (STAGE >= HORNER_STAGES);
    localparam int HI   = ELEM_BITS - 1 - STEP_BITS * (STAGE % HORNER_STAGES);

    function automatic logic [FIELD_BITS-1:0] xtime(input logic [FIELD_BITS-1:0] r,
                                                     input logic [FIELD_BITS-1:0] m);
        logic [FIELD_BITS-1:0] res;
        res = {r[FIELD_BITS-2:0], 1'b0};
        if (r[FIELD_BITS-1])
            res = res ^ m;
        return res;
    endfunction

    logic                  valid_reg;
    item_t                 item_reg;
    logic [FIELD_BITS-1:0] ra_reg;
    logic [FIELD_BITS-1:0] rx_reg;
    logic [FIELD_BITS-1:0] ra_next;
    logic [FIELD_BITS-1:0] rx_next;
    logic [STEP_BITS-1:0]  qbits;

    assign qbits     = IS_X ? item_in.element[HI -: STEP_BITS] : multiplier[HI -: STEP_BITS];
    assign ready_out = !valid_reg || ready_in;

    always_comb
    begin
        ra_next = ra_in;
        rx_next = rx_in;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            if (IS_X)
            begin
                rx_next = xtime(rx_next, mod_low);
                if (qbits[STEP_BITS-1-i])
                    rx_next = rx_next ^ ra_in;
            end
            else
            begin
                ra_next = xtime(ra_next, mod_low);
                if (qbits[STEP_BITS-1-i])
                    ra_next = ra_next ^ FIELD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_out)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            item_reg <= item_in;
            ra_reg   <= ra_next;
            rx_reg   <= rx_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;
    assign ra_out    = ra_reg;
    assign rx_out    = rx_reg;

endmodule

// ----- dv/gf2m_affine_hash_match_tb.sv -----
`timescale 1ns / 100ps

module gf2m_affine_hash_match_tb;

    import gfah_pkg::*;

    // Field size the block is built with; the mirror below follows it.
    localparam int FIELD_BITS = 64;
    localparam logic [ELEM_BITS-1:0] FIELD_MASK = {ELEM_BITS{1'b1}} >> (ELEM_BITS - FIELD_BITS);
    localparam logic [ELEM_BITS-1:0] ALL_ONES = {ELEM_BITS{1'b1}};

    // Pipeline is 17 deep; give the tail a comfortable margin.
    localparam int DRAIN_CYCLES = 60;
    // Timeout above the slowest legal run, with a wide safety factor.
    localparam int CYCLE_LIMIT = 400000;

    localparam int RANDOM_PHASES = 16;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int FLOOD_ITEMS = 120;

    // Receiver stall styles, switched at random intervals.
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    // One expected hash result, in port order.
    typedef struct packed {
        logic [ELEM_BITS-1:0] matched_element;
        logic [ELEM_BITS-1:0] hash_code;
        logic                 is_match;
        logic                 is_last_res;
    } hash_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [ELEM_BITS-1:0]    element;
    logic                    is_last;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [ELEM_BITS-1:0]    matched_element;
    logic [ELEM_BITS-1:0]    hash_code;
    logic                    is_match;
    logic                    is_last_res;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [ELEM_BITS-1:0]    cfg_data;

    // Mirror of the configuration registers, updated on each accepted write.
    logic [ELEM_BITS-1:0]     mirror_multiplier;
    logic [ELEM_BITS-1:0]     mirror_addend;
    logic [ELEM_BITS-1:0]     mirror_modulus;
    logic [HASH_CTL_BITS-1:0] mirror_hash_bits;
    logic [ELEM_BITS-1:0]     mirror_target;

    // Hashes the block still owes us, oldest first.
    hash_result_t expected_hashes[$];

    int mismatch_count = 0;
    int cycle_count = 0;

    // Sender burst shaping.
    int burst_left = 0;
    bit sender_gaps_on = 1'b1;

    // Receiver: long hold-off request plus its own random pattern.
    int       hold_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_period = 4;
    int       rx_duty = 1;
    int       rx_phase = 0;

    gf2m_affine_hash_match #(
        .FIELD_BITS(FIELD_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .element(element),
        .is_last(is_last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .matched_element(matched_element),
        .hash_code(hash_code),
        .is_match(is_match),
        .is_last_res(is_last_res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Hash prediction over GF(2)[x] / f, f = x^FIELD_BITS + modulus_low
    // ------------------------------------------------------------------

    // r * x mod f
    function automatic logic [ELEM_BITS-1:0] gf_mul_x(input logic [ELEM_BITS-1:0] r);
        logic top;
        top = r[FIELD_BITS-1];
        r = (r << 1) & FIELD_MASK;
        if (top)
            r = r ^ (mirror_modulus & FIELD_MASK);
        return r;
    endfunction

    // p * q mod f by Horner over the bits of q; p must already be reduced
    function automatic logic [ELEM_BITS-1:0] gf_mulmod(input logic [ELEM_BITS-1:0] p,
                                                       input logic [ELEM_BITS-1:0] q);
        logic [ELEM_BITS-1:0] r;
        r = '0;
        for (int i = ELEM_BITS - 1; i >= 0; i--)
        begin
            r = gf_mul_x(r);
            if (q[i])
                r = r ^ p;
        end
        return r;
    endfunction

    // Low-k mask; k of 64 and above keeps the whole word, k of 0 keeps nothing.
    function automatic logic [ELEM_BITS-1:0] hash_mask(input logic [HASH_CTL_BITS-1:0] k);
        if (k >= ELEM_BITS)
            return ALL_ONES;
        return (64'd1 << k) - 64'd1;
    endfunction

    function automatic logic [ELEM_BITS-1:0] hash_of(input logic [ELEM_BITS-1:0] x);
        logic [ELEM_BITS-1:0] a_red;
        logic [ELEM_BITS-1:0] r;
        // multiplier is reduced first, which matters only for narrow fields
        a_red = gf_mulmod(64'd1, mirror_multiplier);
        r = gf_mulmod(a_red, x) ^ mirror_addend;
        return r & hash_mask(mirror_hash_bits);
    endfunction

    function automatic hash_result_t predict_hash(input logic [ELEM_BITS-1:0] x,
                                                  input logic last);
        hash_result_t res;
        res.hash_code = hash_of(x);
        // target bits above k can never be matched
        res.is_match = (res.hash_code == mirror_target);
        res.matched_element = res.is_match ? x : '0;
        res.is_last_res = last;
        return res;
    endfunction

    function automatic logic [ELEM_BITS-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random word biased toward the extremes.
    function automatic logic [ELEM_BITS-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ALL_ONES;
            2: return 64'd1;
            3: return 64'd1 << $urandom_range(0, ELEM_BITS - 1);
            default: return rand64();
        endcase
    endfunction

    // Hash width: small widths make matches common, wide ones cover k >= 64.
    function automatic logic [HASH_CTL_BITS-1:0] rand_hash_bits();
        case ($urandom_range(0, 7))
            0: return '0;
            1, 2: return HASH_CTL_BITS'($urandom_range(1, 6));
            3: return HASH_CTL_BITS'(20);
            4: return HASH_CTL_BITS'(63);
            5: return HASH_CTL_BITS'(64);
            6: return HASH_CTL_BITS'($urandom_range(65, 127));
            default: return HASH_CTL_BITS'($urandom_range(0, 127));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request channel
    // ------------------------------------------------------------------

    // Offer one request and hold it until the block takes it.
    task automatic offer_element(input logic [ELEM_BITS-1:0] x, input logic last);
        @(negedge clk);
        in_valid <= 1'b1;
        element  <= x;
        is_last  <= last;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        expected_hashes.insert(expected_hashes.size(), predict_hash(x, last));
    endtask

    // Drop valid and stay idle for extra cycles.
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Send in bursts of random length with random gaps between them.
    task automatic stream_element(input logic [ELEM_BITS-1:0] x, input logic last);
        offer_element(x, last);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            if (sender_gaps_on && $urandom_range(0, 3) != 0)
                pause_sender($urandom_range(0, 8));
        end
    endtask

    // Stop sending and wait for every outstanding hash to come back.
    task automatic wait_hashes_drained();
        pause_sender(0);
        while (expected_hashes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration channel
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [ELEM_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            REG_MULTIPLIER:  mirror_multiplier = data;
            REG_ADDEND:      mirror_addend = data;
            REG_MODULUS_LOW: mirror_modulus = data;
            REG_HASH_BITS:   mirror_hash_bits = data[HASH_CTL_BITS-1:0];
            REG_TARGET:      mirror_target = data;
            default:         ;  // unmapped index: no register changes
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Target chosen so that seed hashes onto it under the current settings.
    task automatic aim_target_at(input logic [ELEM_BITS-1:0] seed);
        write_reg(REG_TARGET, hash_of(seed));
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern and result checking
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            // long hold-off so the pipeline fills and backs up the requests
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 300);
                rx_period = $urandom_range(2, 9);
                rx_duty = $urandom_range(1, rx_period - 1);
            end
            rx_mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_FREE:     out_stall <= 1'b0;
                RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: out_stall <= ((rx_phase % rx_period) < rx_duty);
                default:     out_stall <= 1'b0;
            endcase
        end
    end

    task automatic check_field(input string name, input logic [ELEM_BITS-1:0] exp_v,
                               input logic [ELEM_BITS-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        hash_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hashes.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual hash %h",
                         $time, hash_code);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_hashes.pop_front();
                check_field("matched_element", exp_r.matched_element, matched_element);
                check_field("hash_code", exp_r.hash_code, hash_code);
                check_field("is_match", exp_r.is_match, is_match);
                check_field("is_last_res", exp_r.is_last_res, is_last_res);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_hashes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: a = 1, b = 0, f = x^64 + x^4 + x^3 + x + 1, k = 20, target 0.
    task automatic test_reset_values();
        stream_element('0, 1'b0);                       // hashes to zero: match
        stream_element(64'd1, 1'b0);
        stream_element(ALL_ONES, 1'b0);
        stream_element(64'h8000_0000_0000_0000, 1'b0);  // top bit only
        stream_element(64'hFFFF_FFFF_FFF0_0000, 1'b1);  // low 20 bits clear: match
    endtask

    task automatic test_register_extremes();
        logic [ELEM_BITS-1:0] seed;

        // Zero hash width, upper data bits set: every element matches target 0.
        // Unmapped indices are written too and must leave the registers alone.
        wait_hashes_drained();
        write_reg(REG_HASH_BITS, 64'hFFFF_FFFF_FFFF_FF80);
        for (int i = int'(REG_TARGET) + 1; i < (1 << CFG_IDX_BITS); i++)
            write_reg(i[CFG_IDX_BITS-1:0], rand64());
        stream_element(rand64(), 1'b0);
        stream_element(ALL_ONES, 1'b1);

        // All-ones operands and modulus, full 64-bit hash.
        wait_hashes_drained();
        write_reg(REG_MULTIPLIER, ALL_ONES);
        write_reg(REG_ADDEND, ALL_ONES);
        write_reg(REG_MODULUS_LOW, ALL_ONES);
        write_reg(REG_HASH_BITS, 64'd64);
        seed = rand64();
        aim_target_at(seed);
        stream_element(seed, 1'b0);
        stream_element('0, 1'b0);   // hash is the addend alone
        stream_element(seed, 1'b1);

        // Reducible modulus f = x^64, width beyond 64.
        wait_hashes_drained();
        write_reg(REG_MULTIPLIER, 64'h8000_0000_0000_0000);
        write_reg(REG_ADDEND, '0);
        write_reg(REG_MODULUS_LOW, '0);
        write_reg(REG_HASH_BITS, 64'd127);
        aim_target_at(64'd3);
        stream_element(64'd3, 1'b0);
        stream_element(64'd1, 1'b0);
        stream_element(ALL_ONES, 1'b1);

        // One-bit hash with a target that has bits above it: never matches.
        wait_hashes_drained();
        write_reg(REG_MULTIPLIER, rand64());
        write_reg(REG_HASH_BITS, 64'd1);
        write_reg(REG_TARGET, 64'h8000_0000_0000_0002);
        stream_element(rand64(), 1'b0);
        stream_element(rand64(), 1'b1);
        stream_element(ALL_ONES, 1'b0);
        stream_element('0, 1'b1);

        // Width 63, zero multiplier: hash is the masked addend for any input.
        wait_hashes_drained();
        write_reg(REG_MULTIPLIER, '0);
        write_reg(REG_ADDEND, rand64());
        write_reg(REG_MODULUS_LOW, 64'd27);
        write_reg(REG_HASH_BITS, 64'd63);
        aim_target_at(ALL_ONES);
        stream_element(ALL_ONES, 1'b0);
        stream_element(rand64(), 1'b1);
    endtask

    // Random settings, each phase a stream of sets ended by is_last.
    task automatic test_random_settings();
        logic [ELEM_BITS-1:0] seed;
        logic [ELEM_BITS-1:0] x;
        logic [ELEM_BITS-1:0] hb_data;
        int sent;
        int set_len;
        bit broken_set;
        logic last;

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_hashes_drained();
            write_reg(REG_MULTIPLIER, rand_word());
            write_reg(REG_ADDEND, rand_word());
            write_reg(REG_MODULUS_LOW, ($urandom_range(0, 3) == 0) ? 64'd27 : rand_word());
            hb_data = rand64();
            hb_data[HASH_CTL_BITS-1:0] = rand_hash_bits();
            write_reg(REG_HASH_BITS, hb_data);
            seed = rand64();
            case ($urandom_range(0, 5))
                0, 1: aim_target_at(seed);
                2:    write_reg(REG_TARGET, rand64() & hash_mask(mirror_hash_bits));
                3:    write_reg(REG_TARGET, rand64());
                4:    write_reg(REG_TARGET, '0);
                default: write_reg(REG_TARGET, rand_word());
            endcase

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                set_len = $urandom_range(1, 12);
                // a few sets carry a scrambled last marker
                broken_set = ($urandom_range(0, 9) == 0);
                for (int j = 0; j < set_len; j++)
                begin
                    case ($urandom_range(0, 9))
                        0, 1: x = seed;
                        2:    x = 64'd1 << $urandom_range(0, ELEM_BITS - 1);
                        3:    x = 64'($urandom_range(0, 255));
                        4:    x = ~(64'd1 << $urandom_range(0, ELEM_BITS - 1));
                        default: x = rand64();
                    endcase
                    last = broken_set ? 1'($urandom_range(0, 1)) : (j == set_len - 1);
                    stream_element(x, last);
                    sent++;
                end
            end
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so the
    // pipeline fills and stalls the request side; then the sender waits for
    // every outstanding result before going on.
    task automatic test_backpressure();
        logic [ELEM_BITS-1:0] seed;
        wait_hashes_drained();
        write_reg(REG_MULTIPLIER, rand64());
        write_reg(REG_ADDEND, rand64());
        write_reg(REG_MODULUS_LOW, 64'd27);
        write_reg(REG_HASH_BITS, 64'd3);
        seed = rand64();
        aim_target_at(seed);
        @(posedge clk);
        hold_left = HOLD_OFF_CYCLES;
        sender_gaps_on = 1'b0;
        for (int i = 0; i < FLOOD_ITEMS; i++)
            stream_element(($urandom_range(0, 4) == 0) ? seed : rand64(), (i % 8) == 7);
        sender_gaps_on = 1'b1;
        wait_hashes_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        element = '0;
        is_last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mirror_multiplier = 64'd1;
        mirror_addend = '0;
        mirror_modulus = 64'd27;
        mirror_hash_bits = HASH_CTL_BITS'(20);
        mirror_target = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_register_extremes();
        test_random_settings();
        test_backpressure();

        wait_hashes_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
